@@ hdl/lwg_pkg.sv @@
// Package for the Life-with-walls generation step: cell codes, payload structs,
// rule register indexes and the output queue geometry.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package lwg_pkg;

  // Cell codes. The fourth code behaves as a dead cell.
  localparam logic [1:0] CELL_DEAD  = 2'd0;
  localparam logic [1:0] CELL_ALIVE = 2'd1;
  localparam logic [1:0] CELL_WALL  = 2'd2;

  // Rule register indexes on the configuration port.
  localparam logic [1:0] CFG_BIRTH_COUNT  = 2'd0;
  localparam logic [1:0] CFG_SURVIVE_LOW  = 2'd1;
  localparam logic [1:0] CFG_SURVIVE_HIGH = 2'd2;

  // Reset values of the rule registers (B3/S23).
  localparam logic [3:0] BIRTH_COUNT_RESET  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW_RESET  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH_RESET = 4'd3;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One input transaction: a column of three cells plus row markers.
  typedef struct packed {
    logic [1:0] upper_cell;
    logic [1:0] center_cell;
    logic [1:0] lower_cell;
    logic       row_start;
    logic       row_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] next_cell;
    logic       display_bit;
    logic       last_of_row;
  } out_item_t;

  // A held column of the window.
  typedef struct packed {
    logic [1:0] lower;
    logic [1:0] center;
    logic [1:0] upper;
  } column_t;

  // Rule registers as seen by the evaluation logic.
  typedef struct packed {
    logic [3:0] birth_count;
    logic [3:0] survive_low;
    logic [3:0] survive_high;
  } rule_cfg_t;

  // Results pushed into the output queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

@@ hdl/lwg_rule.sv @@
// Next-state evaluation of one centre cell from its three-column neighbourhood.
// Depends on lwg_pkg for cell codes and the column, rule and result types.
`timescale 1ns / 1ps

module lwg_rule (
  input  lwg_pkg::column_t   left,
  input  lwg_pkg::column_t   mid,
  input  lwg_pkg::column_t   right,
  input  logic               last,
  input  lwg_pkg::rule_cfg_t cfg,
  output lwg_pkg::out_item_t result
);
  import lwg_pkg::*;

  logic [3:0] alive_count;
  logic [1:0] next_state;

  // Count the alive neighbours; the centre cell itself is skipped.
  always_comb begin
    alive_count = 4'(left.upper == CELL_ALIVE) + 4'(left.center == CELL_ALIVE)
                + 4'(left.lower == CELL_ALIVE) + 4'(mid.upper == CELL_ALIVE)
                + 4'(mid.lower == CELL_ALIVE) + 4'(right.upper == CELL_ALIVE)
                + 4'(right.center == CELL_ALIVE) + 4'(right.lower == CELL_ALIVE);
  end

  // Walls hold, alive cells survive within the band, others may be born.
  always_comb begin
    case (mid.center)
      CELL_WALL: begin
        next_state = CELL_WALL;
      end
      CELL_ALIVE: begin
        next_state = (alive_count >= cfg.survive_low && alive_count <= cfg.survive_high)
                     ? CELL_ALIVE : CELL_DEAD;
      end
      default: begin
        next_state = (alive_count == cfg.birth_count) ? CELL_ALIVE : CELL_DEAD;
      end
    endcase
  end

  assign result.next_cell   = next_state;
  assign result.display_bit = (next_state != CELL_DEAD);
  assign result.last_of_row = last;

endmodule

@@ hdl/lwg_window.sv @@
// Two-column sliding window of the current row; emits up to two results per column.
// Depends on lwg_pkg and instantiates lwg_rule twice.
`timescale 1ns / 1ps

module lwg_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  lwg_pkg::in_item_t  item,
  input  lwg_pkg::rule_cfg_t cfg,
  output lwg_pkg::push_t     push
);
  import lwg_pkg::*;

  column_t    older;
  column_t    newer;
  logic [1:0] columns_held;

  column_t    incoming;
  column_t    older_eff;
  column_t    newer_eff;
  logic [1:0] held_eff;
  logic       mid_ready;
  out_item_t  mid_result;
  out_item_t  flush_result;

  // A row start clears the window before the column is taken in.
  always_comb begin
    incoming.upper  = item.upper_cell;
    incoming.center = item.center_cell;
    incoming.lower  = item.lower_cell;
    older_eff       = item.row_start ? '0 : older;
    newer_eff       = item.row_start ? '0 : newer;
    held_eff        = item.row_start ? 2'd0 : columns_held;
    mid_ready       = (held_eff != 2'd0);
  end

  // Centre cell of the previous column, now that its right neighbour is here.
  lwg_rule u_mid_rule (
    .left   (older_eff),
    .mid    (newer_eff),
    .right  (incoming),
    .last   (1'b0),
    .cfg    (cfg),
    .result (mid_result)
  );

  // Final cell of the row, with dead cells to its right.
  lwg_rule u_flush_rule (
    .left   (newer_eff),
    .mid    (incoming),
    .right  ('0),
    .last   (1'b1),
    .cfg    (cfg),
    .result (flush_result)
  );

  // Order results: the previous column first, the flushed cell second.
  always_comb begin
    push.count  = advance ? (2'(mid_ready) + 2'(item.row_end)) : 2'd0;
    push.first  = mid_ready ? mid_result : flush_result;
    push.second = flush_result;
  end

  // Shift the window; a row end leaves it empty for the next row.
  always_ff @(posedge clk) begin
    if (rst) begin
      older        <= '0;
      newer        <= '0;
      columns_held <= 2'd0;
    end else if (advance) begin
      if (item.row_end) begin
        older        <= '0;
        newer        <= '0;
        columns_held <= 2'd0;
      end else begin
        older        <= newer_eff;
        newer        <= incoming;
        columns_held <= (held_eff == 2'd2) ? 2'd2 : held_eff + 2'd1;
      end
    end
  end

endmodule

@@ hdl/lwg_out_queue.sv @@
// Small result queue that takes up to two results a cycle and delivers one unless out_stall holds it.
// Depends on lwg_pkg for the result and push types and the queue geometry.
`timescale 1ns / 1ps

module lwg_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  lwg_pkg::push_t     push,
  output logic               room_for_two,
  output logic               out_valid,
  input  logic               out_stall,
  output lwg_pkg::out_item_t out_data
);
  import lwg_pkg::*;

  out_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;
  logic [QUEUE_CNT_W-1:0] fill_next;
  logic                   pop;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = (fill != '0);
  assign out_data     = entries[rd_ptr];
  assign room_for_two = (fill <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign fill_next    = fill + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

  // Storage: entries need no reset.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QUEUE_PTR_W'(1)] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push.count);
      rd_ptr <= rd_ptr + QUEUE_PTR_W'(pop);
      fill   <= fill_next;
    end
  end

endmodule

@@ hdl/life_with_walls_generation_step_top.sv @@
// Top level of the Life-with-walls generation step: input register, rule
// registers, window and result queue. Depends on lwg_pkg, lwg_window, lwg_out_queue.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) takes one column of three
// cells per transaction, streamed left to right along a row; row_start and
// row_end mark the row's first and last columns. The output channel
// (out_valid, out_stall, out_data) returns one transaction per cell, in row
// order, the last one flagged by last_of_row. A column produces the result of
// the previous column's centre cell; a row-end column also flushes its own.
// A result reaches the output through the input register, then the result
// queue, after the column that completes it is accepted.
// Throughput: one column per cycle while in_stall is low. A row-end column
// can cause two results, while the single-result output port drains one result
// per cycle; in_stall rises while a column is held and the queue lacks room
// for two results. If the receiver stalls, results wait in the four-entry
// queue and the input stalls once it holds more than two.
// Reset clears the window, empties the queue and loads B3/S23 into the rule
// registers. The configuration port (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready and should be written only while the block idles.

module life_with_walls_generation_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lwg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lwg_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import lwg_pkg::*;

  in_item_t  item;
  logic      item_valid;
  logic      advance;
  logic      room_for_two;
  rule_cfg_t rule_cfg;
  push_t     push;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && room_for_two;
  assign in_stall  = item_valid && !room_for_two;

  // Rule registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_cfg.birth_count  <= BIRTH_COUNT_RESET;
      rule_cfg.survive_low  <= SURVIVE_LOW_RESET;
      rule_cfg.survive_high <= SURVIVE_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIRTH_COUNT:  rule_cfg.birth_count  <= cfg_data;
        CFG_SURVIVE_LOW:  rule_cfg.survive_low  <= cfg_data;
        CFG_SURVIVE_HIGH: rule_cfg.survive_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: holds one transaction until the window can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  lwg_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (rule_cfg),
    .push    (push)
  );

  lwg_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

@@ tb/sv/lwg_checker.sv @@
`timescale 1ns / 1ps
// Checker for the Life-with-walls generation step: watches the column, result
// and rule-write channels, predicts every cell's next state and compares.
// Depends on lwg_pkg only.

module lwg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lwg_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lwg_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 pending,
  output int                 errors
);

  import lwg_pkg::*;

  // Our own copy of the rule registers and of the column window.
  rule_cfg_t   rules;
  column_t     older_col;
  column_t     newer_col;
  int unsigned cols_held;
  int          mismatch_count;

  // Next states still owed by the block, oldest first.
  out_item_t next_cells[$];

  // Alive cells in one column, optionally leaving out its centre cell.
  function automatic int unsigned alive_in(column_t col, bit skip_centre);
    int unsigned n;
    n = 0;
    if (col.upper == CELL_ALIVE) n++;
    if (!skip_centre && col.center == CELL_ALIVE) n++;
    if (col.lower == CELL_ALIVE) n++;
    return n;
  endfunction

  // Next generation of the centre cell of mid, under the current rules.
  function automatic out_item_t evolve(column_t left, column_t mid, column_t right,
                                       bit last);
    int unsigned n;
    logic [1:0]  nxt;
    out_item_t   r;
    n = alive_in(left, 1'b0) + alive_in(mid, 1'b1) + alive_in(right, 1'b0);
    if (mid.center == CELL_WALL) begin
      nxt = CELL_WALL;
    end else if (mid.center == CELL_ALIVE) begin
      nxt = (n >= rules.survive_low && n <= rules.survive_high) ? CELL_ALIVE : CELL_DEAD;
    end else begin
      // Dead cells and the spare code alike can only be born.
      nxt = (n == rules.birth_count) ? CELL_ALIVE : CELL_DEAD;
    end
    r.next_cell   = nxt;
    r.display_bit = (nxt != CELL_DEAD);
    r.last_of_row = last;
    return r;
  endfunction

  always @(posedge clk) begin
    column_t   col;
    out_item_t want;
    bit        bad;
    if (rst) begin
      rules.birth_count  = BIRTH_COUNT_RESET;
      rules.survive_low  = SURVIVE_LOW_RESET;
      rules.survive_high = SURVIVE_HIGH_RESET;
      older_col      = '0;
      newer_col      = '0;
      cols_held      = 0;
      mismatch_count = 0;
      next_cells.delete();
    end else begin
      // Rule register writes; the spare index is ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIRTH_COUNT:  rules.birth_count  = cfg_data;
          CFG_SURVIVE_LOW:  rules.survive_low  = cfg_data;
          CFG_SURVIVE_HIGH: rules.survive_high = cfg_data;
          default: ;
        endcase
      end

      // Result transaction: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (next_cells.size() == 0) begin
          $display("%0t: result with nothing expected: next_cell %0d display %0b last %0b",
                   $time, out_data.next_cell, out_data.display_bit, out_data.last_of_row);
          mismatch_count++;
        end else begin
          want = next_cells.pop_front();
          bad  = 1'b0;
          if (out_data.next_cell !== want.next_cell) begin
            $display("%0t: next_cell expected %0d, actual %0d",
                     $time, want.next_cell, out_data.next_cell);
            bad = 1'b1;
          end
          if (out_data.display_bit !== want.display_bit) begin
            $display("%0t: display_bit expected %0b, actual %0b",
                     $time, want.display_bit, out_data.display_bit);
            bad = 1'b1;
          end
          if (out_data.last_of_row !== want.last_of_row) begin
            $display("%0t: last_of_row expected %0b, actual %0b",
                     $time, want.last_of_row, out_data.last_of_row);
            bad = 1'b1;
          end
          if (bad) mismatch_count++;
        end
      end

      // Column transaction: slide the window and predict what it completes.
      if (in_valid && !in_stall) begin
        col.upper  = in_data.upper_cell;
        col.center = in_data.center_cell;
        col.lower  = in_data.lower_cell;
        if (in_data.row_start) begin
          older_col = '0;
          newer_col = '0;
          cols_held = 0;
        end
        if (cols_held >= 1) next_cells.push_back(evolve(older_col, newer_col, col, 1'b0));
        older_col = newer_col;
        newer_col = col;
        if (cols_held < 2) cols_held++;
        // A row end also flushes its own column, with dead cells to the right.
        if (in_data.row_end) begin
          next_cells.push_back(evolve(older_col, newer_col, '0, 1'b1));
          older_col = '0;
          newer_col = '0;
          cols_held = 0;
        end
      end
    end
    pending <= next_cells.size();
    errors  <= mismatch_count;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the Life-with-walls generation step: clock, reset, column
// stimulus, rule phases, receiver stalls and the verdict. Depends on lwg_pkg,
// lwg_checker and the block's top level.

module tb;

  import lwg_pkg::*;

  localparam logic [1:0]  CELL_SPARE   = 2'd3;   // the code that behaves as dead
  localparam logic [1:0]  CFG_SPARE    = 2'd3;   // index with no register behind it
  localparam int          PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 235;
  localparam int unsigned QUIET_LIMIT  = 2000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_BIRTH_COUNT;
  logic [3:0] cfg_data  = '0;
  int         pending;
  int         errors;

  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_mode   = 0;
  int unsigned stall_span   = 0;

  life_with_walls_generation_step_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lwg_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall behaviour changes after each randomly drawn span,
  // from never stalling through sparse and dense stalls to long runs.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_column(logic [1:0] up, logic [1:0] mid,
                                           logic [1:0] low, logic first, logic last);
    in_item_t c;
    c.upper_cell  = up;
    c.center_cell = mid;
    c.lower_cell  = low;
    c.row_start   = first;
    c.row_end     = last;
    return c;
  endfunction

  function automatic logic [1:0] random_cell(int unsigned alive_pct);
    if ($urandom_range(0, 99) < alive_pct) return CELL_ALIVE;
    case ($urandom_range(0, 2))
      0:       return CELL_DEAD;
      1:       return CELL_WALL;
      default: return CELL_SPARE;
    endcase
  endfunction

  // Sends one column; valid drops only for a gap between bursts.
  task automatic send_column(input in_item_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 200);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // One row of random width; a ragged row has its markers scrambled.
  task automatic send_row(input int unsigned alive_pct, input bit ragged,
                          inout int unsigned sent);
    int unsigned width;
    in_item_t    col;
    width = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int unsigned i = 0; i < width; i++) begin
      col = make_column(random_cell(alive_pct), random_cell(alive_pct),
                        random_cell(alive_pct), i == 0, i == width - 1);
      if (ragged) begin
        if ($urandom_range(0, 5) == 0) col.row_start = ~col.row_start;
        if ($urandom_range(0, 5) == 0) col.row_end = ~col.row_end;
      end
      send_column(col);
      sent++;
    end
  endtask

  // Lets the block settle: all results back, then a further wait for a column
  // that is still held without a result.
  task automatic drain;
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_rules(input rule_cfg_t r, input bit poke_spare);
    write_reg(CFG_BIRTH_COUNT, r.birth_count);
    write_reg(CFG_SURVIVE_LOW, r.survive_low);
    write_reg(CFG_SURVIVE_HIGH, r.survive_high);
    if (poke_spare) write_reg(CFG_SPARE, 4'($urandom_range(0, 15)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rule_cfg_t   setting;
    int unsigned sent;
    int unsigned density;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed columns under the default rules.
    // A one-column row of alive cells, then one of walls.
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_ALIVE, 1'b1, 1'b1));
    send_column(make_column(CELL_WALL, CELL_WALL, CELL_WALL, 1'b1, 1'b1));
    // A full neighbourhood: the middle cell sees eight alive neighbours.
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_ALIVE, 1'b1, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_ALIVE, 1'b0, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_ALIVE, 1'b0, 1'b1));
    // Spare-code centres, one of them born with three neighbours.
    send_column(make_column(CELL_DEAD, CELL_SPARE, CELL_DEAD, 1'b1, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_SPARE, CELL_ALIVE, 1'b0, 1'b0));
    send_column(make_column(CELL_DEAD, CELL_ALIVE, CELL_DEAD, 1'b0, 1'b1));
    // A row without its start marker after a row end.
    send_column(make_column(CELL_DEAD, CELL_ALIVE, CELL_DEAD, 1'b0, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_WALL, CELL_ALIVE, 1'b0, 1'b1));
    // A start marker in the middle of a row restarts the window.
    send_column(make_column(CELL_SPARE, CELL_SPARE, CELL_SPARE, 1'b0, 1'b0));
    send_column(make_column(CELL_SPARE, CELL_DEAD, CELL_SPARE, 1'b1, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_DEAD, 1'b0, 1'b1));
    // Dead centre with alive cells around it.
    send_column(make_column(CELL_DEAD, CELL_DEAD, CELL_DEAD, 1'b1, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_DEAD, CELL_DEAD, 1'b0, 1'b0));
    send_column(make_column(CELL_ALIVE, CELL_ALIVE, CELL_ALIVE, 1'b0, 1'b1));

    // Random rows, one rule setting per phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1:       setting = '{birth_count: 4'd0,  survive_low: 4'd0, survive_high: 4'd0};
          2:       setting = '{birth_count: 4'd8,  survive_low: 4'd0, survive_high: 4'd8};
          3:       setting = '{birth_count: 4'd8,  survive_low: 4'd8, survive_high: 4'd8};
          4:       setting = '{birth_count: 4'd15, survive_low: 4'd9, survive_high: 4'd15};
          5:       setting = '{birth_count: 4'd3,  survive_low: 4'd5, survive_high: 4'd2};
          6:       setting = '{birth_count: 4'($urandom_range(0, 15)),
                               survive_low: 4'($urandom_range(0, 15)),
                               survive_high: 4'($urandom_range(0, 15))};
          default: setting = '{birth_count: BIRTH_COUNT_RESET,
                               survive_low: SURVIVE_LOW_RESET,
                               survive_high: SURVIVE_HIGH_RESET};
        endcase
        load_rules(setting, phase == 4);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 3))
          0:       density = 15;
          1:       density = 40;
          2:       density = 70;
          default: density = 95;
        endcase
        send_row(density, $urandom_range(0, 6) == 0, sent);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lwg_pkg.sv
hdl/lwg_rule.sv
hdl/lwg_window.sv
hdl/lwg_out_queue.sv
hdl/life_with_walls_generation_step_top.sv
tb/sv/lwg_checker.sv
tb/sv/tb.sv
